// ===== rtl/sts_pkg.sv =====
// shared types and constants of the script token scanner
`default_nettype none

package sts_pkg;

    localparam int KIND_W = 5;
    localparam int VAL_W  = 31;

    localparam logic [KIND_W-1:0] KIND_HASH   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_NAME   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_INT    = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACK = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACK = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd10;
    localparam logic [KIND_W-1:0] KIND_SCOPE  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_COLON  = 5'd12;
    localparam logic [KIND_W-1:0] KIND_STR    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd14;
    localparam logic [KIND_W-1:0] KIND_BAD    = 5'd15;
    localparam logic [KIND_W-1:0] KIND_UNTERM = 5'd16;
    localparam logic [KIND_W-1:0] KIND_END    = 5'd17;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [VAL_W-1:0] VAL_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              has_byte;
        logic [7:0]        text_byte;
        logic              token_end;
        logic [VAL_W-1:0]  number_value;
        logic              last_of_input;
    } t_result;

    // one queue entry holds all results of one input transaction
    typedef struct packed {
        logic    two;
        t_result r1;
        t_result r0;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/sts_front.sv =====
// scanner front end: classifies bytes, keeps scan state, builds result entries
`default_nettype none

module sts_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_full,
    input  wire logic           i_func,
    input  wire logic [7:0]     i_ch,
    output logic                o_ready,
    output sts_pkg::t_push      o_push
);

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_NAME  = 3'd1,
        M_NUM   = 3'd2,
        M_STR   = 3'd3,
        M_ESC   = 3'd4,
        M_COLON = 3'd5
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [sts_pkg::VAL_W-1:0] r_accum, n_accum;

    logic                      eot, is_alpha, is_digit, is_space, take;
    logic [3:0]                digit;
    logic [34:0]               acc_sum;
    logic [sts_pkg::VAL_W-1:0] acc_next;
    logic [7:0]                esc_byte;

    logic                      idle_v, pre_v;
    sts_pkg::t_result          idle_r, pre_r, pre_r2, res0, res1;
    t_mode                     idle_mode;
    logic [sts_pkg::VAL_W-1:0] idle_accum;
    logic                      use_idle, pre_two;

    function automatic sts_pkg::t_result mk(input logic [4:0] kind, input logic has,
                                            input logic [7:0] b, input logic fin,
                                            input logic [30:0] val);
        sts_pkg::t_result r;
        r.kind          = kind;
        r.has_byte      = has;
        r.text_byte     = b;
        r.token_end     = fin;
        r.number_value  = val;
        r.last_of_input = 1'b0;
        return r;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            sts_pkg::CH_HASH:  k = sts_pkg::KIND_HASH;
            8'h28:             k = sts_pkg::KIND_LPAREN;
            8'h29:             k = sts_pkg::KIND_RPAREN;
            8'h7B:             k = sts_pkg::KIND_LBRACE;
            8'h7D:             k = sts_pkg::KIND_RBRACE;
            8'h5B:             k = sts_pkg::KIND_LBRACK;
            8'h5D:             k = sts_pkg::KIND_RBRACK;
            8'h3B:             k = sts_pkg::KIND_SEMI;
            8'h2C:             k = sts_pkg::KIND_COMMA;
            sts_pkg::CH_EQUAL: k = sts_pkg::KIND_ASSIGN;
            default:           k = sts_pkg::KIND_BAD;
        endcase
        return k;
    endfunction

    assign o_ready = !i_full;
    assign take    = i_valid && !i_full;

    assign eot      = i_func || (i_ch == 8'd0);
    assign is_alpha = (i_ch >= 8'h61 && i_ch <= 8'h7A) || (i_ch >= 8'h41 && i_ch <= 8'h5A);
    assign is_digit = (i_ch >= 8'h30 && i_ch <= 8'h39);
    assign is_space = (i_ch == 8'h20) || (i_ch >= 8'h09 && i_ch <= 8'h0D);
    assign digit    = 4'(i_ch - 8'h30);

    // saturating accum * 10 + digit
    assign acc_sum  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + 35'(digit);
    assign acc_next = (acc_sum > 35'(sts_pkg::VAL_MAX)) ? sts_pkg::VAL_MAX
                                                        : acc_sum[sts_pkg::VAL_W-1:0];

    assign esc_byte = (i_ch == sts_pkg::CH_LOW_N) ? sts_pkg::CH_LF :
                      (i_ch == sts_pkg::CH_LOW_T) ? sts_pkg::CH_TAB : i_ch;

    // byte handling from idle
    always_comb begin
        idle_v     = 1'b0;
        idle_r     = mk(sts_pkg::KIND_END, 1'b0, 8'd0, 1'b1, '0);
        idle_mode  = M_IDLE;
        idle_accum = r_accum;
        priority if (eot) begin
            idle_v     = 1'b1;
            idle_accum = '0;
        end else if (is_space) begin
            idle_v = 1'b0;
        end else if (is_alpha) begin
            idle_v    = 1'b1;
            idle_mode = M_NAME;
            idle_r    = mk(sts_pkg::KIND_NAME, 1'b1, i_ch, 1'b0, '0);
        end else if (is_digit) begin
            idle_v     = 1'b1;
            idle_mode  = M_NUM;
            idle_accum = 31'(digit);
            idle_r     = mk(sts_pkg::KIND_INT, 1'b1, i_ch, 1'b0, '0);
        end else if (i_ch == sts_pkg::CH_COLON) begin
            idle_mode = M_COLON;
        end else if (i_ch == sts_pkg::CH_QUOTE) begin
            idle_mode = M_STR;
        end else begin
            idle_v = 1'b1;
            idle_r = mk(single_kind(i_ch), 1'b1, i_ch, 1'b1, '0);
        end
    end

    // mode-specific first result, optionally followed by the idle handling
    always_comb begin
        pre_v    = 1'b0;
        pre_r    = mk(sts_pkg::KIND_NAME, 1'b0, 8'd0, 1'b1, '0);
        pre_r2   = pre_r;
        pre_two  = 1'b0;
        use_idle = 1'b0;
        n_mode   = r_mode;
        n_accum  = r_accum;
        unique case (r_mode)
            M_NAME: begin
                pre_v = 1'b1;
                if (!eot && (is_alpha || is_digit || i_ch == sts_pkg::CH_UNDER)) begin
                    pre_r = mk(sts_pkg::KIND_NAME, 1'b1, i_ch, 1'b0, '0);
                end else begin
                    pre_r    = mk(sts_pkg::KIND_NAME, 1'b0, 8'd0, 1'b1, '0);
                    use_idle = 1'b1;
                end
            end
            M_NUM: begin
                pre_v = 1'b1;
                if (!eot && is_digit) begin
                    n_accum = acc_next;
                    pre_r   = mk(sts_pkg::KIND_INT, 1'b1, i_ch, 1'b0, '0);
                end else begin
                    pre_r    = mk(sts_pkg::KIND_INT, 1'b0, 8'd0, 1'b1, r_accum);
                    use_idle = 1'b1;
                end
            end
            M_STR, M_ESC: begin
                priority if (eot) begin
                    pre_v    = 1'b1;
                    pre_r    = mk(sts_pkg::KIND_UNTERM, 1'b0, 8'd0, 1'b1, '0);
                    use_idle = 1'b1;
                end else if (r_mode == M_ESC) begin
                    pre_v  = 1'b1;
                    pre_r  = mk(sts_pkg::KIND_STR, 1'b1, esc_byte, 1'b0, '0);
                    n_mode = M_STR;
                end else if (i_ch == sts_pkg::CH_QUOTE) begin
                    pre_v  = 1'b1;
                    pre_r  = mk(sts_pkg::KIND_STR, 1'b0, 8'd0, 1'b1, '0);
                    n_mode = M_IDLE;
                end else if (i_ch == sts_pkg::CH_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    pre_v = 1'b1;
                    pre_r = mk(sts_pkg::KIND_STR, 1'b1, i_ch, 1'b0, '0);
                end
            end
            M_COLON: begin
                pre_v = 1'b1;
                if (!eot && i_ch == sts_pkg::CH_COLON) begin
                    pre_r   = mk(sts_pkg::KIND_SCOPE, 1'b1, sts_pkg::CH_COLON, 1'b0, '0);
                    pre_r2  = mk(sts_pkg::KIND_SCOPE, 1'b1, sts_pkg::CH_COLON, 1'b1, '0);
                    pre_two = 1'b1;
                    n_mode  = M_IDLE;
                end else begin
                    pre_r    = mk(sts_pkg::KIND_COLON, 1'b1, sts_pkg::CH_COLON, 1'b1, '0);
                    use_idle = 1'b1;
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase
        if (use_idle) begin
            n_mode  = idle_mode;
            n_accum = idle_accum;
        end
    end

    always_comb begin
        o_push.push      = 1'b0;
        o_push.entry.two = 1'b0;
        res0             = pre_v ? pre_r : idle_r;
        res1             = pre_two ? pre_r2 : idle_r;
        if (pre_v && (pre_two || (use_idle && idle_v))) begin
            o_push.entry.two  = 1'b1;
            res1.last_of_input = 1'b1;
        end else begin
            res0.last_of_input = 1'b1;
        end
        o_push.push     = take && (pre_v || (use_idle && idle_v));
        o_push.entry.r0 = res0;
        o_push.entry.r1 = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_accum <= '0;
        end else if (take) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_queue.sv =====
// small queue of result entries between scanner front and output back end
`default_nettype none

module sts_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sts_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output sts_pkg::t_entry     o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sts_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_back.sv =====
// output back end: sends the one or two results of each queue entry in turn
`default_nettype none

module sts_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire sts_pkg::t_entry i_head,
    input  wire logic            i_ready,
    output logic                 o_valid,
    output sts_pkg::t_result     o_res,
    output logic                 o_pop
);

    logic r_second;
    logic take;

    assign o_valid = !i_empty;
    assign o_res   = r_second ? i_head.r1 : i_head.r0;
    assign take    = o_valid && i_ready;
    assign o_pop   = take && (r_second || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !r_second && i_head.two;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/script_token_scanner.sv =====
// script token scanner top level
// usage:
//   input stream: one text byte per transaction on i_s_tdata; i_s_tuser set
//   marks end of text, and a zero byte ends the text as well.
//   output stream: zero, one or two result transactions per input
//   transaction, in order; o_m_tlast marks the last result of an input.
//   o_m_tuser carries the token class and a has-byte flag, o_m_tdata the
//   decoded text byte, the token end flag and the saturated integer value.
// timing: a result appears in the cycle after the input transaction that
//   causes it, if nothing is queued ahead of it.
// throughput: one input per cycle while the queue is not full; an input that
//   gives two results sends them in turn via the single-result output stage.
// reset: synchronous active low; the scanner returns to idle with the
//   number accumulator cleared and the result queue emptied.
// stalls: a QUEUE_DEPTH entry queue sits between the scanner and the
//   output; the input keeps being taken while the receiver stalls until
//   the queue fills, then o_s_tready drops.
`default_nettype none

module script_token_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // ch
    input  wire logic [0:0]  i_s_tuser,   // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // text_byte, token_end, number_value
    output logic [5:0]       o_m_tuser,   // kind, has_byte
    output logic             o_m_tlast    // last_of_input
);

    sts_pkg::t_push   push;
    sts_pkg::t_entry  head;
    sts_pkg::t_result res;
    logic             full, empty, pop;

    sts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_full  (full),
        .i_func  (i_s_tuser[0]),
        .i_ch    (i_s_tdata),
        .o_ready (o_s_tready),
        .o_push  (push)
    );

    sts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    sts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (res),
        .o_pop   (pop)
    );

    assign o_m_tdata = {res.number_value, res.token_end, res.text_byte};
    assign o_m_tuser = {res.has_byte, res.kind};
    assign o_m_tlast = res.last_of_input;

endmodule

`default_nettype wire

// ===== rtl/sts_checker.sv =====
// port checker for the script token scanner, bound to the top level
`default_nettype none

module sts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] i_m_tdata,
    input wire logic [5:0]  i_m_tuser,
    input wire logic        i_m_tlast
);

    // output queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled result changed");

    // only the closing item of an integer carries a value
    a_value_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tdata[39:9] != 31'd0) |->
            (i_m_tuser[4:0] == sts_pkg::KIND_INT) && i_m_tdata[8] && !i_m_tuser[5])
        else $error("number value outside integer end item");

    // end of text closes its input transaction
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser[4:0] == sts_pkg::KIND_END) |->
            i_m_tlast && i_m_tdata[8] && !i_m_tuser[5])
        else $error("end item not last or not a token end");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
